// File: sv/alfc_pkg.sv
package alfc_pkg;

    // Flag operation kinds
    localparam logic [2:0] MODE_COPY  = 3'd0;
    localparam logic [2:0] MODE_ADD   = 3'd1;
    localparam logic [2:0] MODE_SUB   = 3'd2;
    localparam logic [2:0] MODE_ADC   = 3'd3;
    localparam logic [2:0] MODE_SBB   = 3'd4;
    localparam logic [2:0] MODE_LOGIC = 3'd5;
    localparam logic [2:0] MODE_MUL   = 3'd6;
    localparam logic [2:0] MODE_MULL  = 3'd7;

    // Condition codes that are not evaluated
    localparam logic [3:0] COND_AL = 4'd14;
    localparam logic [3:0] COND_NV = 4'd15;

    // Condition pairs (cond[3:1]); cond[0] inverts the base test
    localparam logic [2:0] CGRP_EQ = 3'd0;
    localparam logic [2:0] CGRP_HS = 3'd1;
    localparam logic [2:0] CGRP_MI = 3'd2;
    localparam logic [2:0] CGRP_VS = 3'd3;
    localparam logic [2:0] CGRP_HI = 3'd4;
    localparam logic [2:0] CGRP_GE = 3'd5;
    localparam logic [2:0] CGRP_GT = 3'd6;

    localparam int unsigned WORD_W = 32;

    // Stage 1 -> stage 2: adder result plus what the flag mux needs
    typedef struct packed {
        logic [2:0]        mode;
        logic [3:0]        cond;
        logic [WORD_W-1:0] arg_one;
        logic [WORD_W-1:0] arg_two;
        logic [1:0]        old_cv;
        logic [WORD_W-1:0] res;
        logic              carry;
        logic              ovf;
    } t_alu_st;

    // Stage 2 -> stage 3: rebuilt flag word
    typedef struct packed {
        logic [WORD_W-1:0] flags;
        logic [3:0]        cond;
    } t_flg_st;

endpackage

// File: sv/alfc_if.sv
// Request channel: deferred-flags record plus condition code
interface alfc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [3:0]  cond;
    logic [31:0] arg_one;
    logic [31:0] arg_two;
    logic [31:0] arg_three;

    modport source (output valid, mode, cond, arg_one, arg_two, arg_three, input ready);
    modport sink   (input valid, mode, cond, arg_one, arg_two, arg_three, output ready);
endinterface

// Result channel: flag word and condition outcome
interface alfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] flags_word;
    logic        cond_holds;
    logic        cond_error;

    modport source (output valid, flags_word, cond_holds, cond_error, input ready);
    modport sink   (input valid, flags_word, cond_holds, cond_error, output ready);
endinterface

// File: sv/alfc_alu.sv
// Stage 1: shared 33-bit adder for add/sub/adc/sbb
module alfc_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_mode,
    input  logic [3:0]           i_cond,
    input  logic [31:0]          i_arg_one,
    input  logic [31:0]          i_arg_two,
    input  logic [31:0]          i_arg_three,
    output logic                 o_valid,
    input  logic                 i_ready,
    output alfc_pkg::t_alu_st    o_data
);

    logic               r_valid;
    alfc_pkg::t_alu_st  r_data;
    alfc_pkg::t_alu_st  n_data;
    logic [31:0]        b_eff;
    logic               cin;
    logic               is_sub;
    logic [32:0]        sum;

    // subtract = a + ~b + carry-in
    assign is_sub = (i_mode == alfc_pkg::MODE_SUB) || (i_mode == alfc_pkg::MODE_SBB);
    assign b_eff  = is_sub ? ~i_arg_two : i_arg_two;

    always_comb begin
        case (i_mode)
            alfc_pkg::MODE_SUB: cin = 1'b1;
            alfc_pkg::MODE_ADC: cin = i_arg_three[0];
            alfc_pkg::MODE_SBB: cin = i_arg_three[0];
            default:            cin = 1'b0;
        endcase
    end

    assign sum = {1'b0, i_arg_one} + {1'b0, b_eff} + 33'(cin);

    always_comb begin
        n_data.mode    = i_mode;
        n_data.cond    = i_cond;
        n_data.arg_one = i_arg_one;
        n_data.arg_two = i_arg_two;
        n_data.old_cv  = i_arg_three[1:0];
        n_data.res     = sum[31:0];
        n_data.carry   = sum[32];
        n_data.ovf     = (sum[31] ^ i_arg_one[31]) & (sum[31] ^ b_eff[31]);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/alfc_flags.sv
// Stage 2: zero detect and NZCV packing
module alfc_flags (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  alfc_pkg::t_alu_st    i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output alfc_pkg::t_flg_st    o_data
);

    logic               r_valid;
    alfc_pkg::t_flg_st  r_data;
    alfc_pkg::t_flg_st  n_data;
    logic [31:0]        a;
    logic [31:0]        b;

    assign a = i_data.arg_one;
    assign b = i_data.arg_two;

    always_comb begin
        n_data.cond = i_data.cond;
        case (i_data.mode)
            alfc_pkg::MODE_COPY: begin
                n_data.flags = a;
            end
            alfc_pkg::MODE_ADD,
            alfc_pkg::MODE_SUB,
            alfc_pkg::MODE_ADC,
            alfc_pkg::MODE_SBB: begin
                n_data.flags = {i_data.res[31], i_data.res == 32'd0,
                                i_data.carry, i_data.ovf, 28'd0};
            end
            alfc_pkg::MODE_LOGIC: begin
                // C from shifter carry-out, V kept
                n_data.flags = {a[31], a == 32'd0, b[0], i_data.old_cv[0], 28'd0};
            end
            alfc_pkg::MODE_MUL: begin
                n_data.flags = {a[31], a == 32'd0, i_data.old_cv, 28'd0};
            end
            default: begin
                // long multiply: N from high word, Z over both words
                n_data.flags = {b[31], (a | b) == 32'd0, i_data.old_cv, 28'd0};
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/alfc_cond.sv
// Stage 3: condition evaluation, drives the output register
module alfc_cond (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  alfc_pkg::t_flg_st    i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_flags_word,
    output logic                 o_cond_holds,
    output logic                 o_cond_error
);

    logic        r_valid;
    logic [31:0] r_flags;
    logic        r_holds;
    logic        r_err;
    logic        n_holds;
    logic        n_err;
    logic        fn, fz, fc, fv;
    logic        base;

    assign fn = i_data.flags[31];
    assign fz = i_data.flags[30];
    assign fc = i_data.flags[29];
    assign fv = i_data.flags[28];

    always_comb begin
        case (i_data.cond[3:1])
            alfc_pkg::CGRP_EQ: base = fz;
            alfc_pkg::CGRP_HS: base = fc;
            alfc_pkg::CGRP_MI: base = fn;
            alfc_pkg::CGRP_VS: base = fv;
            alfc_pkg::CGRP_HI: base = fc & !fz;
            alfc_pkg::CGRP_GE: base = !(fn ^ fv);
            alfc_pkg::CGRP_GT: base = !(fz | (fn ^ fv));
            default:           base = 1'b0;
        endcase
    end

    assign n_err   = (i_data.cond == alfc_pkg::COND_AL) || (i_data.cond == alfc_pkg::COND_NV);
    assign n_holds = !n_err && (base ^ i_data.cond[0]);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_flags <= i_data.flags;
            r_holds <= n_holds;
            r_err   <= n_err;
        end
    end

    assign o_valid      = r_valid;
    assign o_flags_word = r_flags;
    assign o_cond_holds = r_holds;
    assign o_cond_error = r_err;

    a_err_not_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_err |-> !r_holds)
        else $error("condition error with condition holding");

endmodule

// File: sv/arm_lazy_flags_condition_eval.sv
// Latency: three registered stages between request acceptance and result valid (adder, flag pack, condition).
// Throughput: one request per cycle while the output is taken; each stage advances when empty or when its
//   downstream takes its content, so a stalled result holds and nothing is lost.
// Ready is combinational from the output ready through the three stage valids.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; payload is not reset.
module arm_lazy_flags_condition_eval (
    input  logic       i_clk,
    input  logic       i_rst_n,
    alfc_in_if.sink    i_in,
    alfc_out_if.source o_out
);

    // Stage 1 -> 2
    logic               s1_valid;
    logic               s1_ready;
    alfc_pkg::t_alu_st  s1_data;

    // Stage 2 -> 3
    logic               s2_valid;
    logic               s2_ready;
    alfc_pkg::t_flg_st  s2_data;

    // Stage 1: add/subtract with carry-in; sub modes use the inverted right operand
    alfc_alu u_alu (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_mode      (i_in.mode),
        .i_cond      (i_in.cond),
        .i_arg_one   (i_in.arg_one),
        .i_arg_two   (i_in.arg_two),
        .i_arg_three (i_in.arg_three),
        .o_valid     (s1_valid),
        .i_ready     (s1_ready),
        .o_data      (s1_data)
    );

    // Stage 2: pick flag source by operation kind, zero detect, pack NZCV
    alfc_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // Stage 3: condition test; AL and NV flag an error and never hold
    alfc_cond u_cond (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s2_valid),
        .o_ready      (s2_ready),
        .i_data       (s2_data),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_flags_word (o_out.flags_word),
        .o_cond_holds (o_out.cond_holds),
        .o_cond_error (o_out.cond_error)
    );

    // An accepted request always lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> s1_valid)
        else $error("accepted request lost at stage 1");

    // Pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid && !s1_valid && !s2_valid)
        else $error("pipeline not empty after reset");

    // A stalled stage 2 item does not vanish
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid && !s2_ready |=> s2_valid && $stable(s2_data))
        else $error("stage 2 item dropped under stall");

endmodule
